[hdl/bsr_pkg.sv]
// Shared types, constants and helper functions for the bitmap store with rank unit.
package bsr_pkg;

	localparam int WORD_BITS   = 64;
	localparam int WORD_SHIFT  = 6;
	localparam int DEF_WORDS   = 16;
	localparam int ACTION_W    = 4;
	localparam int BIT_INDEX_W = 10;
	localparam int RANGE_W     = 11;
	localparam int WINDEX_W    = 4;
	localparam int COUNT_W     = 11;
	localparam int ADDR_W      = 8;
	localparam int WCNT_W      = 9;
	localparam int PC_W        = $clog2(WORD_BITS + 1);
	localparam int CMDQ_DEPTH  = 2;

	localparam logic [ACTION_W-1:0] ACT_RD_BIT   = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_WR_BIT   = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_LOW_FILL = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_OR_WORD  = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_XOR_WORD = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_CNT_ALL  = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_CNT_BLW  = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_RD_WORD  = 4'd8;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RD_BIT,
		OP_WR_BIT,
		OP_FILL,
		OP_CLEAR,
		OP_OR,
		OP_XOR,
		OP_COUNT,
		OP_RD_WORD
	} bsr_op_t;

	// One decoded command. Words lo..hi are visited; for fill and count the words
	// below full are covered completely and word full only in its low rem bits.
	typedef struct packed {
		bsr_op_t               op;
		logic [ADDR_W-1:0]     lo;
		logic [ADDR_W-1:0]     hi;
		logic [WCNT_W-1:0]     full;
		logic [WORD_SHIFT-1:0] rem;
		logic                  value;
		logic [WORD_BITS-1:0]  data;
	} bsr_cmd_t;

	function automatic logic [WORD_BITS-1:0] low_mask(input logic [WORD_SHIFT-1:0] n);
		return (WORD_BITS'(1) << n) - WORD_BITS'(1);
	endfunction

	function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
		logic [PC_W-1:0] c;
		c = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			c = c + PC_W'(w[i]);
		end
		return c;
	endfunction

endpackage

[hdl/bsr_front.sv]
// Front end: accepts items, decodes each into a command and hands it to the queue.
module bsr_front import bsr_pkg::*; #(
	parameter int WORDS = DEF_WORDS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [ACTION_W-1:0]    action,
	input  logic [BIT_INDEX_W-1:0] bit_pos,
	input  logic                   new_value,
	input  logic [RANGE_W-1:0]     range_length,
	input  logic [RANGE_W-1:0]     rank_limit,
	input  logic [WINDEX_W-1:0]    word_index,
	input  logic [WORD_BITS-1:0]   word_data,
	output logic                   q_push,
	input  logic                   q_full,
	output bsr_cmd_t               q_cmd
);

	localparam logic [WCNT_W-1:0] WORDS_C = WCNT_W'(WORDS);
	localparam logic [ADDR_W-1:0] LAST_C  = ADDR_W'(WORDS - 1);

	bsr_cmd_t cmd_s1;
	logic     v_s1;
	bsr_cmd_t dec;
	logic     accept;

	logic [WCNT_W-1:0] slot;
	logic [WCNT_W-1:0] widx;
	logic [WCNT_W-1:0] fill_full;
	logic [WCNT_W-1:0] rank_full;
	logic              slot_ok;
	logic              widx_ok;

	always_comb begin
		slot      = WCNT_W'(bit_pos[BIT_INDEX_W-1:WORD_SHIFT]);
		widx      = WCNT_W'(word_index);
		fill_full = WCNT_W'(range_length[RANGE_W-1:WORD_SHIFT]);
		rank_full = WCNT_W'(rank_limit[RANGE_W-1:WORD_SHIFT]);
		slot_ok   = slot < WORDS_C;
		widx_ok   = widx < WORDS_C;

		dec       = '0;
		dec.op    = OP_NONE;
		dec.value = new_value;

		unique case (action)
			ACT_RD_BIT, ACT_WR_BIT: begin
				if (slot_ok) begin
					dec.op = (action == ACT_RD_BIT) ? OP_RD_BIT : OP_WR_BIT;
				end
				dec.lo   = ADDR_W'(slot);
				dec.hi   = ADDR_W'(slot);
				dec.data = WORD_BITS'(1) << bit_pos[WORD_SHIFT-1:0];
			end
			ACT_LOW_FILL: begin
				dec.op   = OP_FILL;
				dec.full = fill_full;
				dec.rem  = range_length[WORD_SHIFT-1:0];
				dec.hi   = (fill_full < WORDS_C) ? ADDR_W'(fill_full) : LAST_C;
			end
			ACT_CLEAR: begin
				dec.op = OP_CLEAR;
			end
			ACT_OR_WORD, ACT_XOR_WORD, ACT_RD_WORD: begin
				if (widx_ok) begin
					if (action == ACT_OR_WORD) begin
						dec.op = OP_OR;
					end else if (action == ACT_XOR_WORD) begin
						dec.op = OP_XOR;
					end else begin
						dec.op = OP_RD_WORD;
					end
				end
				dec.lo   = ADDR_W'(widx);
				dec.hi   = ADDR_W'(widx);
				dec.data = word_data;
			end
			ACT_CNT_ALL: begin
				dec.op   = OP_COUNT;
				dec.full = WORDS_C;
				dec.hi   = LAST_C;
			end
			ACT_CNT_BLW: begin
				dec.op   = OP_COUNT;
				dec.full = rank_full;
				dec.rem  = rank_limit[WORD_SHIFT-1:0];
				dec.hi   = (rank_full < WORDS_C) ? ADDR_W'(rank_full) : LAST_C;
			end
			default: begin
				dec.op = OP_NONE;
			end
		endcase
	end

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_push = v_s1;
	assign q_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

[hdl/bsr_cmdq.sv]
// Short command queue between the front end and the execution engine.
module bsr_cmdq import bsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  bsr_cmd_t wr_cmd,
	output logic     empty,
	input  logic     pop,
	output bsr_cmd_t head
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int NW = $clog2(CMDQ_DEPTH + 1);

	bsr_cmd_t        ent_q [CMDQ_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [NW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = cnt_q == NW'(CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

[hdl/bsr_back.sv]
// Execution engine: sweeps the word memory for each command and holds the result.
module bsr_back import bsr_pkg::*; #(
	parameter int WORDS = DEF_WORDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bsr_cmd_t             q_head,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic                 bit_out,
	output logic [COUNT_W-1:0]   count_out,
	output logic [WORD_BITS-1:0] word_out
);

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW = $clog2(WORDS * WORD_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FIN
	} state_t;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORDS-1:0]     vld_q;

	state_t               state_q;
	bsr_cmd_t             cur_q;
	logic [AW-1:0]        iss_q;

	logic                 v_s1;
	logic                 vld_s1;
	logic [AW-1:0]        addr_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	logic [CW-1:0]        acc_q;
	logic                 bit_q;
	logic [WORD_BITS-1:0] word_q;

	logic                 res_v_q;
	logic                 res_bit_q;
	logic [COUNT_W-1:0]   res_cnt_q;
	logic [WORD_BITS-1:0] res_word_q;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 head_sweeps;
	logic                 out_free;

	logic [WORD_BITS-1:0] word_s1;
	logic [WORD_BITS-1:0] rmask;
	logic [WCNT_W-1:0]    w9;
	logic [WORD_BITS-1:0] new_word;
	logic                 wr_en;
	logic [CW-1:0]        acc_nx;
	logic                 bit_nx;
	logic [WORD_BITS-1:0] word_nx;

	assign head_sweeps = !(q_head.op == OP_NONE || q_head.op == OP_CLEAR);
	assign q_pop       = (state_q == ST_IDLE) && !q_empty;
	assign out_free    = !res_v_q || pop;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = iss_q;
		if (state_q == ST_IDLE) begin
			rd_en   = !q_empty && head_sweeps;
			rd_addr = q_head.lo[AW-1:0];
		end else if (state_q == ST_SWEEP) begin
			rd_en = 1'b1;
		end
	end

	// A word that has not been written since reset or the last clear reads as zero.
	always_comb begin
		word_s1  = vld_s1 ? rdata_s1 : '0;
		w9       = WCNT_W'(addr_s1);
		if (w9 < cur_q.full) begin
			rmask = '1;
		end else if (w9 == cur_q.full) begin
			rmask = low_mask(cur_q.rem);
		end else begin
			rmask = '0;
		end

		new_word = word_s1;
		wr_en    = 1'b0;
		acc_nx   = acc_q;
		bit_nx   = bit_q;
		word_nx  = word_q;

		unique case (cur_q.op)
			OP_RD_BIT: begin
				bit_nx = |(word_s1 & cur_q.data);
			end
			OP_WR_BIT: begin
				new_word = cur_q.value ? (word_s1 | cur_q.data) : (word_s1 & ~cur_q.data);
				wr_en    = v_s1;
			end
			OP_FILL: begin
				new_word = cur_q.value ? (word_s1 | rmask) : (word_s1 & ~rmask);
				wr_en    = v_s1;
			end
			OP_OR: begin
				new_word = word_s1 | cur_q.data;
				wr_en    = v_s1;
			end
			OP_XOR: begin
				new_word = word_s1 ^ cur_q.data;
				wr_en    = v_s1;
			end
			OP_COUNT: begin
				acc_nx = acc_q + CW'(popcount(word_s1 & rmask));
			end
			OP_RD_WORD: begin
				word_nx = word_s1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= new_word;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			vld_s1   <= vld_q[rd_addr];
			addr_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			iss_q      <= '0;
			v_s1       <= 1'b0;
			vld_q      <= '0;
			acc_q      <= '0;
			bit_q      <= 1'b0;
			word_q     <= '0;
			res_v_q    <= 1'b0;
			res_bit_q  <= 1'b0;
			res_cnt_q  <= '0;
			res_word_q <= '0;
		end else begin
			v_s1 <= rd_en;
			if (res_v_q && pop) begin
				res_v_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (v_s1) begin
				acc_q  <= acc_nx;
				bit_q  <= bit_nx;
				word_q <= word_nx;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cur_q  <= q_head;
						acc_q  <= '0;
						bit_q  <= 1'b0;
						word_q <= '0;
						if (!head_sweeps) begin
							if (q_head.op == OP_CLEAR) begin
								vld_q <= '0;
							end
							state_q <= ST_FIN;
						end else begin
							iss_q <= q_head.lo[AW-1:0] + AW'(1);
							if (q_head.lo == q_head.hi) begin
								state_q <= ST_DRAIN;
							end else begin
								state_q <= ST_SWEEP;
							end
						end
					end
				end
				ST_SWEEP: begin
					iss_q <= iss_q + AW'(1);
					if (iss_q == cur_q.hi[AW-1:0]) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The last word is finished in this cycle, so its share goes straight
					// into the result register when that is free.
					if (out_free) begin
						res_v_q    <= 1'b1;
						res_bit_q  <= bit_nx;
						res_cnt_q  <= COUNT_W'(acc_nx);
						res_word_q <= word_nx;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_v_q    <= 1'b1;
						res_bit_q  <= bit_q;
						res_cnt_q  <= COUNT_W'(acc_q);
						res_word_q <= word_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty     = !res_v_q;
	assign bit_out   = res_bit_q;
	assign count_out = res_cnt_q;
	assign word_out  = res_word_q;

endmodule

[hdl/bitmap_store_with_rank_unit.sv]
// Bitmap store with rank: front end, command queue and sweeping execution engine.
// The engine takes the next item from the queue only once the previous one has gone into
// the result register; fill and count actions take longer the more words they visit,
// since each word passes through the single read port of the word memory, and a full
// count or fill visits all WORDS words.
// Reset clears the map at once through per-word valid bits and empties both queues.
module bitmap_store_with_rank_unit import bsr_pkg::*; #(
	parameter int WORDS = DEF_WORDS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [ACTION_W-1:0]    action,
	input  logic [BIT_INDEX_W-1:0] bit_pos,
	input  logic                   new_value,
	input  logic [RANGE_W-1:0]     range_length,
	input  logic [RANGE_W-1:0]     rank_limit,
	input  logic [WINDEX_W-1:0]    word_index,
	input  logic [WORD_BITS-1:0]   word_data,
	output logic                   empty,
	input  logic                   pop,
	output logic                   bit_out,
	output logic [COUNT_W-1:0]     count_out,
	output logic [WORD_BITS-1:0]   word_out
);

	logic     fq_push;
	logic     fq_full;
	bsr_cmd_t fq_cmd;
	logic     bq_empty;
	logic     bq_pop;
	bsr_cmd_t bq_head;

	bsr_front #(
		.WORDS(WORDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.bit_pos     (bit_pos),
		.new_value   (new_value),
		.range_length(range_length),
		.rank_limit  (rank_limit),
		.word_index  (word_index),
		.word_data   (word_data),
		.q_push      (fq_push),
		.q_full      (fq_full),
		.q_cmd       (fq_cmd)
	);

	bsr_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fq_push),
		.full  (fq_full),
		.wr_cmd(fq_cmd),
		.empty (bq_empty),
		.pop   (bq_pop),
		.head  (bq_head)
	);

	bsr_back #(
		.WORDS(WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (bq_empty),
		.q_head   (bq_head),
		.q_pop    (bq_pop),
		.empty    (empty),
		.pop      (pop),
		.bit_out  (bit_out),
		.count_out(count_out),
		.word_out (word_out)
	);

endmodule

[verif/bitmap_store_with_rank_unit_tb.sv]
// Self-checking testbench for the bitmap store with rank unit.
module bitmap_store_with_rank_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsr_pkg::*;

	localparam int WORDS        = DEF_WORDS;
	localparam int MAP_BITS     = WORDS * WORD_BITS;
	localparam int PHASE_ITEMS  = 470;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACT_RD_WORD + 1'b1;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = '1;

	typedef struct {
		logic                 bit_v;
		logic [COUNT_W-1:0]   count;
		logic [WORD_BITS-1:0] word;
	} rank_result_t;

	class rank_scoreboard;
		logic [WORD_BITS-1:0] map_words [WORDS];
		rank_result_t         pending_results [$];
		int                   mismatch_count;

		function new();
			foreach (map_words[i]) map_words[i] = '0;
			mismatch_count = 0;
		endfunction

		function int count_below(input int limit);
			int lim;
			int c;
			lim = (limit > MAP_BITS) ? MAP_BITS : limit;
			c = 0;
			for (int b = 0; b < lim; b++) begin
				c += map_words[b / WORD_BITS][b % WORD_BITS];
			end
			return c;
		endfunction

		// Updates the predicted map and queues the result this transaction must produce.
		function void apply_request(input logic [ACTION_W-1:0] act,
				input logic [BIT_INDEX_W-1:0] bi, input logic nv,
				input logic [RANGE_W-1:0] rl, input logic [RANGE_W-1:0] rk,
				input logic [WINDEX_W-1:0] wi, input logic [WORD_BITS-1:0] wd);
			rank_result_t r;
			int n;
			r.bit_v = 1'b0;
			r.count = '0;
			r.word  = '0;
			case (act)
				ACT_RD_BIT: begin
					r.bit_v = map_words[bi / WORD_BITS][bi % WORD_BITS];
				end
				ACT_WR_BIT: begin
					map_words[bi / WORD_BITS][bi % WORD_BITS] = nv;
				end
				ACT_LOW_FILL: begin
					n = (rl > MAP_BITS) ? MAP_BITS : int'(rl);
					for (int b = 0; b < n; b++) begin
						map_words[b / WORD_BITS][b % WORD_BITS] = nv;
					end
				end
				ACT_CLEAR: begin
					foreach (map_words[i]) map_words[i] = '0;
				end
				ACT_OR_WORD: begin
					map_words[wi] = map_words[wi] | wd;
				end
				ACT_XOR_WORD: begin
					map_words[wi] = map_words[wi] ^ wd;
				end
				ACT_CNT_ALL: begin
					r.count = COUNT_W'(count_below(MAP_BITS));
				end
				ACT_CNT_BLW: begin
					r.count = COUNT_W'(count_below(int'(rk)));
				end
				ACT_RD_WORD: begin
					r.word = map_words[wi];
				end
				default: begin
				end
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_result(input logic b, input logic [COUNT_W-1:0] c,
				input logic [WORD_BITS-1:0] w);
			rank_result_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result: bit_out %0d, count_out %0d, word_out %h", b, c, w);
				mismatch_count++;
				return;
			end
			e = pending_results.pop_front();
			if (b !== e.bit_v) begin
				$error("bit_out mismatch: expected %0d, actual %0d", e.bit_v, b);
				mismatch_count++;
			end
			if (c !== e.count) begin
				$error("count_out mismatch: expected %0d, actual %0d", e.count, c);
				mismatch_count++;
			end
			if (w !== e.word) begin
				$error("word_out mismatch: expected %h, actual %h", e.word, w);
				mismatch_count++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	logic [ACTION_W-1:0]    action = '0;
	logic [BIT_INDEX_W-1:0] bit_pos = '0;
	logic                   new_value = 1'b0;
	logic [RANGE_W-1:0]     range_length = '0;
	logic [RANGE_W-1:0]     rank_limit = '0;
	logic [WINDEX_W-1:0]    word_index = '0;
	logic [WORD_BITS-1:0]   word_data = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic                   bit_out;
	logic [COUNT_W-1:0]     count_out;
	logic [WORD_BITS-1:0]   word_out;

	rank_scoreboard sb;
	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	bit  hold_request = 1'b0;
	int  idle_cycles = 0;

	bitmap_store_with_rank_unit #(.WORDS(WORDS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.bit_pos      (bit_pos),
		.new_value    (new_value),
		.range_length (range_length),
		.rank_limit   (rank_limit),
		.word_index   (word_index),
		.word_data    (word_data),
		.empty        (empty),
		.pop          (pop),
		.bit_out      (bit_out),
		.count_out    (count_out),
		.word_out     (word_out)
	);

	always #6 clk = ~clk;

	// All drivers use nonblocking updates, so this block sees the values that held at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (push && !full) begin
				sb.apply_request(action, bit_pos, new_value, range_length, rank_limit,
					word_index, word_data);
			end
			if (pop && !empty) begin
				sb.check_result(bit_out, count_out, word_out);
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_request(input logic [ACTION_W-1:0] act,
			input logic [BIT_INDEX_W-1:0] bi, input logic nv,
			input logic [RANGE_W-1:0] rl, input logic [RANGE_W-1:0] rk,
			input logic [WINDEX_W-1:0] wi, input logic [WORD_BITS-1:0] wd);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		action       <= act;
		bit_pos      <= bi;
		new_value    <= nv;
		range_length <= rl;
		rank_limit   <= rk;
		word_index   <= wi;
		word_data    <= wd;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Lengths cluster around word boundaries and past the end of the map.
	function automatic logic [RANGE_W-1:0] pick_length();
		case ($urandom_range(5))
			0: return RANGE_W'($urandom_range(70));
			1: return RANGE_W'(WORD_BITS * $urandom_range(WORDS) + $urandom_range(2) - 1);
			2: return RANGE_W'($urandom_range(2047, MAP_BITS));
			default: return RANGE_W'($urandom_range(MAP_BITS));
		endcase
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_word();
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			2: return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_random_request();
		logic [ACTION_W-1:0] act;
		int sel;
		sel = $urandom_range(99);
		if (sel < 14) act = ACT_WR_BIT;
		else if (sel < 26) act = ACT_RD_BIT;
		else if (sel < 36) act = ACT_LOW_FILL;
		else if (sel < 38) act = ACT_CLEAR;
		else if (sel < 46) act = ACT_OR_WORD;
		else if (sel < 54) act = ACT_XOR_WORD;
		else if (sel < 61) act = ACT_CNT_ALL;
		else if (sel < 80) act = ACT_CNT_BLW;
		else if (sel < 93) act = ACT_RD_WORD;
		else act = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
		send_request(act, BIT_INDEX_W'($urandom), 1'($urandom), pick_length(),
			pick_length(), WINDEX_W'($urandom), pick_word());
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: boundaries of the map, saturating lengths and limits, every action.
		send_request(ACT_RD_WORD, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_CNT_ALL, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_WR_BIT, '0, 1'b1, '0, '0, '0, '0);
		send_request(ACT_WR_BIT, '1, 1'b1, '0, '0, '0, '0);
		send_request(ACT_RD_BIT, '1, 1'b0, '0, '0, '0, '0);
		send_request(ACT_RD_BIT, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_CNT_BLW, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_CNT_BLW, '0, 1'b0, '0, RANGE_W'(1), '0, '0);
		send_request(ACT_CNT_BLW, '0, 1'b0, '0, RANGE_W'(MAP_BITS), '0, '0);
		send_request(ACT_CNT_BLW, '0, 1'b0, '0, '1, '0, '0);
		send_request(ACT_LOW_FILL, '0, 1'b1, RANGE_W'(WORD_BITS), '0, '0, '0);
		send_request(ACT_LOW_FILL, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_LOW_FILL, '0, 1'b1, '1, '0, '0, '0);
		send_request(ACT_CNT_ALL, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_LOW_FILL, '0, 1'b0, RANGE_W'(WORD_BITS - 1), '0, '0, '0);
		send_request(ACT_XOR_WORD, '0, 1'b0, '0, '0, '1, '1);
		send_request(ACT_OR_WORD, '0, 1'b0, '0, '0, '0, {(WORD_BITS / 2){2'b10}});
		send_request(ACT_RD_WORD, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_RD_WORD, '0, 1'b0, '0, '0, '1, '0);
		send_request(ACT_CNT_BLW, '0, 1'b0, '0, RANGE_W'(1000), '0, '0);
		send_request(ACT_CLEAR, '0, 1'b0, '0, '0, '0, '0);
		send_request(ACT_RD_BIT, BIT_INDEX_W'(MAP_BITS / 2), 1'b0, '0, '0, '0, '0);
		send_request(ACT_UNUSED_LO, '1, 1'b1, '1, '1, '1, '1);
		send_request(ACT_UNUSED_HI, '1, 1'b1, '1, '1, '1, '1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			// With the sender at full rate the hold-off backs the block up until full rises.
			if (phase == 0) hold_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random_request();
			end
		end
		push <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/bsr_pkg.sv
hdl/bsr_front.sv
hdl/bsr_cmdq.sv
hdl/bsr_back.sv
hdl/bitmap_store_with_rank_unit.sv
verif/bitmap_store_with_rank_unit_tb.sv
